/* rtl/qdgf_pkg.sv */
// Shared types, constants and the quadrature transition table for the
// quadrature decoder with glitch filter. No dependencies.

package qdgf_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int APB_ADDR_WIDTH      = 2;
    localparam int APB_DATA_WIDTH      = 32;
    localparam int INTERVAL_WIDTH      = 16;
    localparam int TIME_WIDTH          = 32;
    localparam int POSITION_WIDTH      = 32;

    localparam logic [INTERVAL_WIDTH-1:0] MIN_INTERVAL_RESET = 16'd15;

    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_MIN_EDGE_INTERVAL = 2'd0;

    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_INIT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    typedef struct packed {
        logic [1:0]            mode;
        logic [1:0]            ab;
        logic [TIME_WIDTH-1:0] time_us;
    } qdgf_item_t;

    function automatic logic [1:0] qdgf_step_lookup(input logic [1:0] old_ab,
                                                    input logic [1:0] new_ab);
        logic [1:0] code;
        begin
            case ({old_ab, new_ab})
                4'b0001: code = STEP_DOWN;
                4'b0010: code = STEP_UP;
                4'b0100: code = STEP_UP;
                4'b0111: code = STEP_DOWN;
                4'b1000: code = STEP_DOWN;
                4'b1011: code = STEP_UP;
                4'b1101: code = STEP_UP;
                4'b1110: code = STEP_DOWN;
                default: code = STEP_NONE;
            endcase
            return code;
        end
    endfunction

endpackage

/* rtl/qdgf_regs.sv */
// APB-style configuration register bank holding the minimum edge interval.
// Depends on qdgf_pkg.

module qdgf_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qdgf_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [qdgf_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [qdgf_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output logic [qdgf_pkg::INTERVAL_WIDTH-1:0] min_edge_interval
);
    import qdgf_pkg::*;

    logic [INTERVAL_WIDTH-1:0] min_interval_reg;
    logic [INTERVAL_WIDTH-1:0] min_interval_next;
    logic                      write_hit;

    assign pready    = 1'b1;
    assign write_hit = psel && penable && pwrite && (paddr == ADDR_MIN_EDGE_INTERVAL);

    always_comb
    begin
        min_interval_next = min_interval_reg;
        if (write_hit)
        begin
            min_interval_next = pwdata[INTERVAL_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RESET;
        end
        else
        begin
            min_interval_reg <= min_interval_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_MIN_EDGE_INTERVAL)
        begin
            prdata = {{(APB_DATA_WIDTH-INTERVAL_WIDTH){1'b0}}, min_interval_reg};
        end
    end

    assign min_edge_interval = min_interval_reg;

endmodule

/* rtl/qdgf_core.sv */
// Decoder datapath: input register, filter and transition state, result register.
// Depends on qdgf_pkg.

module qdgf_core #(
    parameter int COUNT_WIDTH = qdgf_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  qdgf_pkg::qdgf_item_t                 in_item,
    input  logic [qdgf_pkg::INTERVAL_WIDTH-1:0]  min_edge_interval,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qdgf_pkg::POSITION_WIDTH-1:0] position,
    output logic                                 accepted,
    output logic signed [1:0]                    step
);
    import qdgf_pkg::*;

    logic                        in_valid_reg;
    qdgf_item_t                  item_reg;
    logic                        out_valid_reg;
    logic [POSITION_WIDTH-1:0]   position_reg;
    logic                        accepted_reg;
    logic [1:0]                  step_reg;

    logic [1:0]                  last_ab_reg;
    logic [1:0]                  last_ab_next;
    logic [TIME_WIDTH-1:0]       last_time_reg;
    logic [TIME_WIDTH-1:0]       last_time_next;
    logic [COUNT_WIDTH-1:0]      count_reg;
    logic [COUNT_WIDTH-1:0]      count_next;
    logic                        accepted_next;
    logic [1:0]                  step_next;

    logic                        advance;
    logic                        load;
    logic [TIME_WIDTH-1:0]       gap;
    logic                        gap_ok;
    logic [1:0]                  table_step;
    logic signed [COUNT_WIDTH-1:0] count_signed;
    logic signed [63:0]          count_wide;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    assign gap        = item_reg.time_us - last_time_reg;
    assign gap_ok     = gap >= {{(TIME_WIDTH-INTERVAL_WIDTH){1'b0}}, min_edge_interval};
    assign table_step = qdgf_step_lookup(last_ab_reg, item_reg.ab);

    always_comb
    begin
        last_ab_next   = last_ab_reg;
        last_time_next = last_time_reg;
        count_next     = count_reg;
        accepted_next  = 1'b0;
        step_next      = STEP_NONE;
        case (item_reg.mode)
            MODE_EDGE:
            begin
                if (gap_ok)
                begin
                    accepted_next  = 1'b1;
                    step_next      = table_step;
                    last_ab_next   = item_reg.ab;
                    last_time_next = item_reg.time_us;
                    count_next     = count_reg
                                   + {{(COUNT_WIDTH-1){table_step[1]}}, table_step[0]};
                end
            end
            MODE_INIT:
            begin
                last_ab_next   = item_reg.ab;
                last_time_next = item_reg.time_us;
                count_next     = '0;
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign count_signed = count_next;
    assign count_wide   = 64'(count_signed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_ab_reg   <= '0;
            last_time_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                last_ab_reg   <= last_ab_next;
                last_time_reg <= last_time_next;
                count_reg     <= count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
        if (advance)
        begin
            position_reg <= count_wide[POSITION_WIDTH-1:0];
            accepted_reg <= accepted_next;
            step_reg     <= step_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign accepted  = accepted_reg;
    assign step      = step_reg;

endmodule

/* rtl/quadrature_decoder_glitch_filter_unit.sv */
// Top level of the 4x quadrature decoder with edge-interval glitch filter.
// Depends on qdgf_pkg, qdgf_regs and qdgf_core.
//
//   Channel   Handshake            Beat contents
//   input     in_valid / in_stall  mode, level_a, level_b, time_us
//   output    out_valid/ out_stall position, accepted, step
//   config    APB psel/penable     min_edge_interval at byte address 0
//
// Each beat goes from the input register via filter compare and count adder
// to the result register; one beat is taken each cycle unless output stalls.
// Reset clears the state, the count and the interval to 15 microseconds.
// A stalled output holds its result; the input stalls only when the input
// register holds a beat and the result register holds a stalled beat.

module quadrature_decoder_glitch_filter_unit #(
    parameter int COUNT_WIDTH = qdgf_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qdgf_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [qdgf_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [qdgf_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           mode,
    input  logic                                 level_a,
    input  logic                                 level_b,
    input  logic [qdgf_pkg::TIME_WIDTH-1:0]      time_us,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qdgf_pkg::POSITION_WIDTH-1:0] position,
    output logic                                 accepted,
    output logic signed [1:0]                    step
);
    import qdgf_pkg::*;

    logic [INTERVAL_WIDTH-1:0] min_edge_interval;
    qdgf_item_t                in_item;

    assign in_item.mode    = mode;
    assign in_item.ab      = {level_a, level_b};
    assign in_item.time_us = time_us;

    qdgf_regs u_regs (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .min_edge_interval (min_edge_interval)
    );

    qdgf_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .in_item           (in_item),
        .min_edge_interval (min_edge_interval),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .position          (position),
        .accepted          (accepted),
        .step              (step)
    );

`ifndef SYNTHESIS
    a_step_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (step != STEP_NONE) |-> accepted)
        else $error("Non-zero step reported without an accepted edge.");

    a_step_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step == STEP_NONE) || (step == STEP_UP) || (step == STEP_DOWN))
        else $error("Illegal step code on the output.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled while the result register could advance.");
`endif

endmodule

/* sim/qdgf_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the quadrature decoder testbench: a cycle-free predictor of the
// decoder state and a queue of expected result beats. Depends on qdgf_pkg.

package qdgf_tb_pkg;

    import qdgf_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [1:0] TRANSITION_CODE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    typedef struct packed {
        logic [POSITION_WIDTH-1:0] position;
        logic                      accepted;
        logic [1:0]                step;
    } quad_result_t;

    class position_scoreboard;

        logic [INTERVAL_WIDTH-1:0] edge_interval;
        logic [1:0]                ab_state;
        logic [TIME_WIDTH-1:0]     edge_time;
        logic [POSITION_WIDTH-1:0] count;
        quad_result_t              expected_beats[$];
        int unsigned               failures;

        function new();
            edge_interval = MIN_INTERVAL_RESET;
            ab_state      = 2'b00;
            edge_time     = '0;
            count         = '0;
            failures      = 0;
        endfunction

        function void set_interval(input logic [INTERVAL_WIDTH-1:0] value);
            edge_interval = value;
        endfunction

        function int unsigned pending_count();
            return expected_beats.size();
        endfunction

        // Called once for every accepted input beat.
        function void note_item(input logic [1:0] item_mode, input logic a, input logic b,
                                input logic [TIME_WIDTH-1:0] stamp);
            logic [1:0]            new_ab;
            logic [TIME_WIDTH-1:0] gap;
            logic [1:0]            code;
            quad_result_t          beat;
            new_ab        = {a, b};
            beat.accepted = 1'b0;
            beat.step     = STEP_NONE;
            case (item_mode)
                MODE_EDGE:
                begin
                    gap = stamp - edge_time;
                    if (gap >= TIME_WIDTH'(edge_interval))
                    begin
                        code          = TRANSITION_CODE[{ab_state, new_ab}];
                        beat.accepted = 1'b1;
                        beat.step     = code;
                        edge_time     = stamp;
                        ab_state      = new_ab;
                        if (code == STEP_UP)
                            count = count + 1'b1;
                        else if (code == STEP_DOWN)
                            count = count - 1'b1;
                    end
                end
                MODE_INIT:
                begin
                    ab_state  = new_ab;
                    edge_time = stamp;
                    count     = '0;
                end
                MODE_CLEAR:
                    count = '0;
                default:
                    ;
            endcase
            beat.position = count;
            expected_beats.push_back(beat);
        endfunction

        function void check_result(input logic [POSITION_WIDTH-1:0] got_position,
                                   input logic got_accepted, input logic [1:0] got_step);
            quad_result_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: position %0d, accepted %0d, step %0d",
                       $signed(got_position), got_accepted, $signed(got_step));
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            if (got_position !== want.position)
            begin
                $error("position mismatch: expected %0d, actual %0d",
                       $signed(want.position), $signed(got_position));
                failures++;
            end
            if (got_accepted !== want.accepted)
            begin
                $error("accepted mismatch: expected %0d, actual %0d",
                       want.accepted, got_accepted);
                failures++;
            end
            if (got_step !== want.step)
            begin
                $error("step mismatch: expected %0d, actual %0d",
                       $signed(want.step), $signed(got_step));
                failures++;
            end
        endfunction

    endclass

endpackage

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for quadrature_decoder_glitch_filter_unit: drives encoder
// beats and register writes, checks every result. Depends on qdgf_pkg, qdgf_tb_pkg.

module tb_top;

    import qdgf_pkg::*;
    import qdgf_tb_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                mode;
    logic                      level_a;
    logic                      level_b;
    logic [TIME_WIDTH-1:0]     time_us;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [POSITION_WIDTH-1:0] position;
    logic                      accepted;
    logic signed [1:0]         step;

    position_scoreboard        sb;
    int unsigned               sender_idle_pct = 0;
    int unsigned               receiver_stall_pct = 0;
    logic [INTERVAL_WIDTH-1:0] cur_interval = MIN_INTERVAL_RESET;
    logic [TIME_WIDTH-1:0]     gen_time = '0;
    logic [1:0]                gen_ab = 2'b00;

    quadrature_decoder_glitch_filter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .level_a   (level_a),
        .level_b   (level_b),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .accepted  (accepted),
        .step      (step)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall = rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(mode, level_a, level_b, time_us);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(position, accepted, step);
    end

    task automatic send_item(input logic [1:0] m, input logic a, input logic b,
                             input logic [TIME_WIDTH-1:0] stamp);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = m;
        level_a  = a;
        level_b  = b;
        time_us  = stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_interval(input logic [INTERVAL_WIDTH-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_MIN_EDGE_INTERVAL;
        pwdata  = APB_DATA_WIDTH'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        sb.set_interval(value);
        cur_interval = value;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        pwdata  = $urandom();
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_WIDTH'(value))
        begin
            $error("min_edge_interval mismatch: expected %0d, actual %0d", value, prdata);
            sb.failures++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned           pick;
        int unsigned           shape;
        logic [1:0]            next_ab;
        logic [TIME_WIDTH-1:0] gap;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            shape = $urandom_range(99);
            if (shape < 25)
                gap = (cur_interval == 0) ? '0 : $urandom_range(32'(cur_interval) - 1, 0);
            else if (shape < 35)
                gap = TIME_WIDTH'(cur_interval);
            else if (shape < 45)
                gap = (cur_interval == 0) ? '0 : TIME_WIDTH'(cur_interval) - 1;
            else if (shape < 95)
                gap = TIME_WIDTH'(cur_interval) + $urandom_range(40, 1);
            else
                gap = $urandom();
            gen_time = gen_time + gap;
            shape = $urandom_range(9);
            if (shape < 6)
                next_ab = gen_ab ^ ($urandom_range(1) ? 2'b01 : 2'b10);
            else if (shape < 8)
                next_ab = gen_ab;
            else
                next_ab = gen_ab ^ 2'b11;
            send_item(MODE_EDGE, next_ab[1], next_ab[0], gen_time);
            gen_ab = next_ab;
        end
        else if (pick < 87)
        begin
            gen_time = $urandom();
            gen_ab   = 2'($urandom_range(3));
            send_item(MODE_INIT, gen_ab[1], gen_ab[0], gen_time);
        end
        else if (pick < 92)
            send_item(MODE_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
        else if (pick < 95)
            send_item(MODE_IGNORED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom());
        else
            send_item(MODE_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
    endtask

    initial
    begin
        logic [INTERVAL_WIDTH-1:0] plan [5];
        sb       = new();
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        mode     = MODE_EDGE;
        level_a  = 1'b0;
        level_b  = 1'b0;
        time_us  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at the reset interval of 15 microseconds.
        send_item(MODE_EDGE,    1'b0, 1'b1, 32'd0);
        send_item(MODE_INIT,    1'b0, 1'b0, 32'd100);
        send_item(MODE_EDGE,    1'b1, 1'b0, 32'd115);
        send_item(MODE_EDGE,    1'b1, 1'b1, 32'd120);
        send_item(MODE_EDGE,    1'b1, 1'b1, 32'd130);
        send_item(MODE_EDGE,    1'b0, 1'b0, 32'd200);
        send_item(MODE_EDGE,    1'b0, 1'b0, 32'd300);
        send_item(MODE_EDGE,    1'b0, 1'b1, 32'd400);
        send_item(MODE_EDGE,    1'b1, 1'b1, 32'd500);
        send_item(MODE_EDGE,    1'b1, 1'b0, 32'd600);
        send_item(MODE_EDGE,    1'b0, 1'b0, 32'd700);
        send_item(MODE_EDGE,    1'b0, 1'b1, 32'd800);
        send_item(MODE_EDGE,    1'b1, 1'b1, 32'd813);
        send_item(MODE_IGNORED, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR,   1'b1, 1'b0, 32'h5A5A_A5A5);
        send_item(MODE_EDGE,    1'b1, 1'b1, 32'd900);
        send_item(MODE_INIT,    1'b1, 1'b1, 32'hFFFF_FFF8);
        send_item(MODE_EDGE,    1'b1, 1'b0, 32'h0000_0007);
        send_item(MODE_EDGE,    1'b0, 1'b0, 32'h0000_000A);
        send_item(MODE_EDGE,    1'b0, 1'b0, 32'h0000_0016);
        send_item(MODE_EDGE,    1'b0, 1'b1, 32'hFFFF_FFFF);
        send_item(MODE_IGNORED, 1'b0, 1'b0, 32'd0);
        drain();

        plan[0] = '0;
        plan[1] = '1;
        plan[2] = 16'd1;
        plan[3] = 16'($urandom_range(65534, 2));
        plan[4] = MIN_INTERVAL_RESET;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_interval(plan[phase]);
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 78;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 78;
                end
                default:
                begin
                    sender_idle_pct    = 22;
                    receiver_stall_pct = 22;
                end
            endcase
            gen_time = (phase == 2) ? 32'hFFFF_FF00 : $urandom();
            gen_ab   = 2'($urandom_range(3));
            send_item(MODE_INIT, gen_ab[1], gen_ab[0], gen_time);
            repeat (126) send_random_item();
            drain();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending_count() == 0)
            $display("quadrature_decoder_glitch_filter_unit regression: pass");
        else
            $display("quadrature_decoder_glitch_filter_unit regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("quadrature_decoder_glitch_filter_unit regression: fail");
        $finish;
    end

endmodule

/* quadrature_decoder_glitch_filter_unit.f */
rtl/qdgf_pkg.sv
rtl/qdgf_regs.sv
rtl/qdgf_core.sv
rtl/quadrature_decoder_glitch_filter_unit.sv
sim/qdgf_tb_pkg.sv
sim/tb_top.sv
